// ----- rtl/core/hcka_pkg.sv -----
package hcka_pkg;

   localparam int unsigned CHAN_W    = 8;
   localparam int unsigned HUE_W     = 13;
   localparam int unsigned UNIT_W    = 11;
   localparam int unsigned NUM_W     = 18;   // 1024*255 and 960*255+254 both fit
   localparam int unsigned RECIP_SH  = 26;   // NUM_W + CHAN_W keeps floor exact
   localparam int unsigned RECIP_W   = RECIP_SH + 1;
   localparam int unsigned PROD_W    = NUM_W + RECIP_W;
   localparam int unsigned TBL_DEPTH = 1 << CHAN_W;
   localparam int unsigned NSTAGE    = 6;

   localparam int unsigned RECIP_ONE = 1 << RECIP_SH;
   // ceil(2^26 / 255), used for the value scaling
   localparam logic [RECIP_W-1:0] VAL_RECIP = RECIP_W'((RECIP_ONE + 254) / 255);

   localparam logic [HUE_W-1:0]  HUE_SECTOR = HUE_W'(960);
   localparam logic [HUE_W-1:0]  HUE_FULL   = HUE_W'(5760);
   localparam logic [UNIT_W-1:0] UNIT_ONE   = UNIT_W'(1024);

   localparam int unsigned CSR_AW = 5;
   localparam int unsigned CSR_DW = 32;

   localparam logic [2:0] REG_HUE_LOW  = 3'd0;
   localparam logic [2:0] REG_HUE_HIGH = 3'd1;
   localparam logic [2:0] REG_SAT_LOW  = 3'd2;
   localparam logic [2:0] REG_SAT_HIGH = 3'd3;
   localparam logic [2:0] REG_VAL_LOW  = 3'd4;
   localparam logic [2:0] REG_VAL_HIGH = 3'd5;

   typedef logic [CHAN_W-1:0] chan_type;

   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } pix_type;

   // after max/min search
   typedef struct packed {
      pix_type    pix;
      chan_type   mx;
      chan_type   delta;
      chan_type   absdiff;
      logic       neg;
      sector_type sector;
   } st2_type;

   // reciprocals and numerators ready
   typedef struct packed {
      pix_type            pix;
      logic [RECIP_W-1:0] recip_mx;
      logic [RECIP_W-1:0] recip_dl;
      logic [NUM_W-1:0]   sat_num;
      logic [NUM_W-1:0]   hue_num;
      logic [NUM_W-1:0]   val_num;
      logic               neg;
      logic               dl_zero;
      sector_type         sector;
   } st3_type;

   // quotients
   typedef struct packed {
      pix_type           pix;
      logic [UNIT_W-1:0] sat_q;
      logic [UNIT_W-1:0] hue_q;
      logic [UNIT_W-1:0] val_q;
      logic              neg;
      logic              dl_zero;
      sector_type        sector;
   } st4_type;

   // final hue, combined sat/val range flag
   typedef struct packed {
      pix_type          pix;
      logic [HUE_W-1:0] hue;
      logic             sv_ok;
   } st5_type;

   typedef struct packed {
      pix_type  pix;
      chan_type alpha;
   } st6_type;

endpackage

// ----- rtl/core/hsv_chroma_key_alpha_core.sv -----
// HSV chroma-key matte.
//
// Input channel (req_*): one RGB pixel per transfer, 8 bits per channel.
// Result channel (rsp_*): the same pixel with alpha 0 when its hue,
// saturation and value all fall inside the programmed inclusive ranges,
// alpha 255 otherwise.
// CSR port: APB-style, six bound registers at byte offsets 0x00..0x14
// (hue_low, hue_high, sat_low, sat_high, val_low, val_high); always ready,
// no wait states, reads return the register value.
//
// Throughput is one pixel per clock while the receiver does not stall; the six stages
// are the input register, max/min search, reciprocal table lookup, reciprocal
// multiply, hue assembly, and hue compare into the output register.
// Reset (synchronous, active high) empties the pipeline and loads the
// bounds with full ranges, so every pixel is keyed out until reprogrammed.
// When the receiver stalls, the result holds and upstream stages keep
// filling empty slots; req_stall rises only once every stage is occupied.
module hsv_chroma_key_alpha_core
   import hcka_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CHAN_W-1:0]    req_red_in,
   input  logic [CHAN_W-1:0]    req_green_in,
   input  logic [CHAN_W-1:0]    req_blue_in,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CHAN_W-1:0]    rsp_red_out,
   output logic [CHAN_W-1:0]    rsp_green_out,
   output logic [CHAN_W-1:0]    rsp_blue_out,
   output logic [CHAN_W-1:0]    rsp_alpha_out,

   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [CSR_AW-1:0]    paddr,
   input  logic [CSR_DW-1:0]    pwdata,
   output logic [CSR_DW-1:0]    prdata,
   output logic                 pready
);

   // ---------------------------------------------------------------
   // CSRs
   // ---------------------------------------------------------------
   logic [HUE_W-1:0]  hue_low_ff, hue_high_ff;
   logic [UNIT_W-1:0] sat_low_ff, sat_high_ff, val_low_ff, val_high_ff;
   logic [2:0]        csr_idx;
   logic              csr_wr;

   assign pready  = 1'b1;
   assign csr_idx = paddr[4:2];
   assign csr_wr  = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_low_ff  <= '0;
         hue_high_ff <= HUE_FULL;
         sat_low_ff  <= '0;
         sat_high_ff <= UNIT_ONE;
         val_low_ff  <= '0;
         val_high_ff <= UNIT_ONE;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_HUE_LOW:  hue_low_ff  <= pwdata[HUE_W-1:0];
            REG_HUE_HIGH: hue_high_ff <= pwdata[HUE_W-1:0];
            REG_SAT_LOW:  sat_low_ff  <= pwdata[UNIT_W-1:0];
            REG_SAT_HIGH: sat_high_ff <= pwdata[UNIT_W-1:0];
            REG_VAL_LOW:  val_low_ff  <= pwdata[UNIT_W-1:0];
            REG_VAL_HIGH: val_high_ff <= pwdata[UNIT_W-1:0];
            default: ;  // unmapped offsets ignored
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_HUE_LOW:  prdata = CSR_DW'(hue_low_ff);
         REG_HUE_HIGH: prdata = CSR_DW'(hue_high_ff);
         REG_SAT_LOW:  prdata = CSR_DW'(sat_low_ff);
         REG_SAT_HIGH: prdata = CSR_DW'(sat_high_ff);
         REG_VAL_LOW:  prdata = CSR_DW'(val_low_ff);
         REG_VAL_HIGH: prdata = CSR_DW'(val_high_ff);
         default:      prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Pipeline control: a stage advances when it is empty or the stage
   // after it advances, so bubbles collapse under a result stall.
   // valid_ff[0] is stage 1 (input register) ... valid_ff[5] the output.
   // ---------------------------------------------------------------
   logic [NSTAGE-1:0] valid_ff, valid_in, adv;

   always_comb begin
      adv[NSTAGE-1] = ~valid_ff[NSTAGE-1] | ~rsp_stall;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         adv[k] = ~valid_ff[k] | adv[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < NSTAGE; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   assign req_stall = ~adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Reciprocal table: ceil(2^26 / d). With numerators below 2^18 the
   // product shifted down by 26 gives the exact floor quotient.
   // Entry 0 is never used for a nonzero numerator.
   // ---------------------------------------------------------------
   logic [RECIP_W-1:0] recip_tbl [TBL_DEPTH];

   for (genvar gi = 0; gi < TBL_DEPTH; gi++) begin : g_recip
      localparam int unsigned Div = (gi == 0) ? 1 : gi;
      localparam logic [RECIP_W-1:0] Recip = RECIP_W'((RECIP_ONE + Div - 1) / Div);
      assign recip_tbl[gi] = Recip;
   end

   // ---------------------------------------------------------------
   // Stage 1: input register
   // ---------------------------------------------------------------
   pix_type st1_ff, st1_in;

   assign st1_in = '{red: req_red_in, green: req_green_in, blue: req_blue_in};

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         st1_ff <= st1_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: max/min, sector and signed difference.
   // Red, then green, then blue wins a tie for the maximum.
   // ---------------------------------------------------------------
   st2_type st2_ff, st2_in;

   always_comb begin
      chan_type          r, g, b, mn;
      logic signed [8:0] diff;
      r = st1_ff.red;
      g = st1_ff.green;
      b = st1_ff.blue;
      mn = (r < g) ? r : g;
      mn = (b < mn) ? b : mn;
      st2_in.pix = st1_ff;
      if (r >= g && r >= b) begin
         st2_in.sector = SECT_RED;
         st2_in.mx     = r;
         diff          = $signed({1'b0, g}) - $signed({1'b0, b});
      end else if (g >= b) begin
         st2_in.sector = SECT_GREEN;
         st2_in.mx     = g;
         diff          = $signed({1'b0, b}) - $signed({1'b0, r});
      end else begin
         st2_in.sector = SECT_BLUE;
         st2_in.mx     = b;
         diff          = $signed({1'b0, r}) - $signed({1'b0, g});
      end
      st2_in.delta   = st2_in.mx - mn;
      st2_in.neg     = diff[8];
      st2_in.absdiff = diff[8] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         st2_ff <= st2_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: table lookups and numerators.
   // floor(-x/d) = -floor((x + d - 1)/d), so negative hue offsets get
   // d - 1 added to the numerator and are subtracted later.
   // ---------------------------------------------------------------
   st3_type st3_ff, st3_in;

   always_comb begin
      logic [NUM_W-1:0] bias;
      bias = st2_ff.neg ? NUM_W'(st2_ff.delta - 8'd1) : '0;
      st3_in.pix      = st2_ff.pix;
      st3_in.recip_mx = recip_tbl[st2_ff.mx];
      st3_in.recip_dl = recip_tbl[st2_ff.delta];
      st3_in.sat_num  = NUM_W'({st2_ff.delta, 10'b0});
      st3_in.val_num  = NUM_W'({st2_ff.mx, 10'b0});
      // 960 = 1024 - 64
      st3_in.hue_num  = NUM_W'({st2_ff.absdiff, 10'b0}) - NUM_W'({st2_ff.absdiff, 6'b0})
                        + bias;
      st3_in.neg      = st2_ff.neg;
      st3_in.dl_zero  = (st2_ff.delta == '0);
      st3_in.sector   = st2_ff.sector;
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         st3_ff <= st3_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: reciprocal multiplies (18 x 27)
   // ---------------------------------------------------------------
   st4_type st4_ff, st4_in;

   always_comb begin
      logic [PROD_W-1:0] sat_p, hue_p, val_p;
      sat_p = PROD_W'(st3_ff.sat_num) * PROD_W'(st3_ff.recip_mx);
      hue_p = PROD_W'(st3_ff.hue_num) * PROD_W'(st3_ff.recip_dl);
      val_p = PROD_W'(st3_ff.val_num) * PROD_W'(VAL_RECIP);
      st4_in.pix     = st3_ff.pix;
      st4_in.sat_q   = sat_p[RECIP_SH +: UNIT_W];
      st4_in.hue_q   = hue_p[RECIP_SH +: UNIT_W];
      st4_in.val_q   = val_p[RECIP_SH +: UNIT_W];
      st4_in.neg     = st3_ff.neg;
      st4_in.dl_zero = st3_ff.dl_zero;
      st4_in.sector  = st3_ff.sector;
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         st4_ff <= st4_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 5: hue assembly with wrap, saturation/value range checks
   // ---------------------------------------------------------------
   st5_type st5_ff, st5_in;

   always_comb begin
      logic [HUE_W-1:0]          offs;
      logic signed [HUE_W:0]     h;
      unique case (st4_ff.sector)
         SECT_RED:   offs = '0;
         SECT_GREEN: offs = HUE_W'({HUE_SECTOR, 1'b0});
         SECT_BLUE:  offs = HUE_W'({HUE_SECTOR, 2'b0});
         default:    offs = '0;
      endcase
      if (st4_ff.neg) begin
         h = $signed({1'b0, offs}) - $signed((HUE_W + 1)'(st4_ff.hue_q));
      end else begin
         h = $signed({1'b0, offs}) + $signed((HUE_W + 1)'(st4_ff.hue_q));
      end
      if (h < 0) begin
         h = h + $signed({1'b0, HUE_FULL});
      end
      st5_in.pix   = st4_ff.pix;
      st5_in.hue   = st4_ff.dl_zero ? '0 : h[HUE_W-1:0];
      st5_in.sv_ok = (st4_ff.sat_q >= sat_low_ff) && (st4_ff.sat_q <= sat_high_ff)
                     && (st4_ff.val_q >= val_low_ff) && (st4_ff.val_q <= val_high_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         st5_ff <= st5_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 6: hue range check, alpha, output register
   // ---------------------------------------------------------------
   st6_type st6_ff, st6_in;

   always_comb begin
      logic keyed;
      keyed = st5_ff.sv_ok && (st5_ff.hue >= hue_low_ff) && (st5_ff.hue <= hue_high_ff);
      st6_in.pix   = st5_ff.pix;
      st6_in.alpha = keyed ? '0 : '1;
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         st6_ff <= st6_in;
      end
   end

   assign rsp_valid     = valid_ff[NSTAGE-1];
   assign rsp_red_out   = st6_ff.pix.red;
   assign rsp_green_out = st6_ff.pix.green;
   assign rsp_blue_out  = st6_ff.pix.blue;
   assign rsp_alpha_out = st6_ff.alpha;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (valid_ff == '1))
      else $error("input stalled with an empty pipeline slot");

   a_hue_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[4] |-> (st5_ff.hue < HUE_FULL))
      else $error("hue out of range");

   a_quot_bounded: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> (st4_ff.sat_q <= UNIT_ONE && st4_ff.val_q <= UNIT_ONE
                       && st4_ff.hue_q <= HUE_SECTOR))
      else $error("quotient out of range");

   a_grey_hue_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[3] && adv[4] && st4_ff.dl_zero) |=> (st5_ff.hue == '0))
      else $error("grey pixel with nonzero hue");

   a_alpha_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_alpha_out == '0 || rsp_alpha_out == '1))
      else $error("alpha not 0 or 255");

endmodule
